### src/nft_pkg.sv
// Shared types, constants and twiddle tables of the negacyclic FFT unit.
// No dependencies; imported by the transform unit and nft_bfly.
package nft_pkg;

    localparam int HALF_LEN     = 1024;
    localparam int FRAC_BITS    = 16;
    localparam int TWIDDLE_BITS = 30;

    localparam int FULL_LEN = 2 * HALF_LEN;
    localparam int LOGN     = $clog2(HALF_LEN);
    localparam int AW       = LOGN + 1;            // work memory address bits
    localparam int SW       = $clog2(LOGN + 1);    // stage counter bits
    localparam int TW_W     = TWIDDLE_BITS + 2;    // signed twiddle width
    localparam int RB_SH    = LOGN + FRAC_BITS;    // backward scaling shift

    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;
    localparam logic [63:0] TW_STEP = PI_Q62 / HALF_LEN;

    localparam logic [1:0] MODE_FWD  = 2'd0;
    localparam logic [1:0] MODE_BWD  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [63:0] sample_re;
        logic signed [63:0] sample_im;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] out_re;
        logic signed [63:0] out_im;
        logic               data_ok;
        logic               last_result;
    } t_out_item;

    // butterfly datapath phase enables
    typedef struct packed {
        logic lo_en;
        logic hi_en;
        logic cmb_en;
    } t_bf_ctl;

    typedef logic [TW_W-1:0] t_tw_tab [HALF_LEN];

    function automatic logic [AW-1:0] f_rev(input logic [AW-1:0] v);
        logic [AW-1:0] r;
        for (int b = 0; b < AW; b++) begin
            r[AW-1-b] = v[b];
        end
        return r;
    endfunction

    function automatic logic [63:0] f_q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] f_div_sin(input int k, input logic [63:0] v);
        case (k)
            1:       return v / 64'd6;
            2:       return v / 64'd20;
            3:       return v / 64'd42;
            4:       return v / 64'd72;
            5:       return v / 64'd110;
            6:       return v / 64'd156;
            7:       return v / 64'd210;
            8:       return v / 64'd272;
            9:       return v / 64'd342;
            10:      return v / 64'd420;
            default: return v / 64'd506;
        endcase
    endfunction

    function automatic logic [63:0] f_div_cos(input int k, input logic [63:0] v);
        case (k)
            1:       return v / 64'd2;
            2:       return v / 64'd12;
            3:       return v / 64'd30;
            4:       return v / 64'd56;
            5:       return v / 64'd90;
            6:       return v / 64'd132;
            7:       return v / 64'd182;
            8:       return v / 64'd240;
            9:       return v / 64'd306;
            10:      return v / 64'd380;
            default: return v / 64'd462;
        endcase
    endfunction

    function automatic logic [63:0] f_q62_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = f_q62_mul(x, x);
        term = x;
        sum  = x;
        for (int k = 1; k <= 11; k++) begin
            term = f_div_sin(k, f_q62_mul(term, x2));
            sum  = (k % 2 == 1) ? sum - term : sum + term;
        end
        return sum;
    endfunction

    function automatic logic [63:0] f_q62_cos(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = f_q62_mul(x, x);
        term = ONE_Q62;
        sum  = ONE_Q62;
        for (int k = 1; k <= 11; k++) begin
            term = f_div_cos(k, f_q62_mul(term, x2));
            sum  = (k % 2 == 1) ? sum - term : sum + term;
        end
        return sum;
    endfunction

    function automatic logic [TW_W-1:0] f_to_tw(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << (61 - TWIDDLE_BITS))) >> (62 - TWIDDLE_BITS);
        return r[TW_W-1:0];
    endfunction

    // angle folded into [0, pi/4]; want_sin picks the sine entry
    function automatic logic [TW_W-1:0] f_tw_entry(input int t, input logic want_sin);
        logic [63:0]     a;
        logic [TW_W-1:0] c;
        logic [TW_W-1:0] s;
        if (t <= HALF_LEN / 4) begin
            a = TW_STEP * 64'(t);
            c = f_to_tw(f_q62_cos(a));
            s = f_to_tw(f_q62_sin(a));
        end else if (t <= HALF_LEN / 2) begin
            a = TW_STEP * 64'(HALF_LEN / 2 - t);
            c = f_to_tw(f_q62_sin(a));
            s = f_to_tw(f_q62_cos(a));
        end else if (t <= HALF_LEN / 2 + HALF_LEN / 4) begin
            a = TW_STEP * 64'(t - HALF_LEN / 2);
            c = -f_to_tw(f_q62_sin(a));
            s = f_to_tw(f_q62_cos(a));
        end else begin
            a = TW_STEP * 64'(HALF_LEN - t);
            c = -f_to_tw(f_q62_cos(a));
            s = f_to_tw(f_q62_sin(a));
        end
        return want_sin ? s : c;
    endfunction

    function automatic t_tw_tab f_tab(input logic want_sin);
        t_tw_tab tab;
        for (int t = 0; t < HALF_LEN; t++) begin
            tab[t] = f_tw_entry(t, want_sin);
        end
        return tab;
    endfunction

    localparam t_tw_tab COS_TAB = f_tab(1'b0);
    localparam t_tw_tab SIN_TAB = f_tab(1'b1);

endpackage

### src/negacyclic_fft_transform_unit.sv
// Negacyclic ring transform over an in-place radix-2 FFT of length 2N.
// Depends on nft_pkg, nft_ram (work memories) and nft_bfly (products).
//
//  channel | signals                          | carries
//  --------+----------------------------------+---------------------------
//  in      | i_in_valid / o_in_ready / i_in_item   | loads and read requests
//  out     | o_out_valid / i_out_ready / o_out_item | one result per read
//
// Forward load writes one slot per item; a backward load writes two (ST_LOADB2).
// The last load starts a zero sweep of N slots, then log2(2N) stages of N
// butterflies; issues alternate with idle slots (single write port, two
// writes per butterfly), and the pipeline drains at the end of each stage.
// A read passes ST_RD1, ST_RD2 (backward), ST_RDOUT; output held until taken.
// Reset clears control and output registers; memories are written before read.
module negacyclic_fft_transform_unit import nft_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOADB2 = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_FFT    = 3'd3;
    localparam logic [2:0] ST_RD1    = 3'd4;
    localparam logic [2:0] ST_RD2    = 3'd5;
    localparam logic [2:0] ST_RDOUT  = 3'd6;

    logic [2:0]    r_state;
    logic          r_dir, r_ready;
    logic [AW-1:0] r_cnt, r_ridx;

    logic [AW-1:0]      r_b2addr;
    logic [63:0]        r_bre, r_bim;
    logic               r_blast;
    logic [LOGN-1:0]    r_swp;

    logic [LOGN-1:0] r_b;
    logic [SW-1:0]   r_stg;
    logic            r_first, r_idone;
    logic [5:1]      r_s;
    logic [AW-1:0]   r_ai [5:1];
    logic [AW-1:0]   r_aj [5:1];
    logic signed [TW_W-1:0] r_wr, r_wi;
    logic [63:0]     r_a1re, r_a1im, r_a2re, r_a2im;

    logic [63:0] r_mag;
    logic        r_neg;
    t_out_item   r_pend;
    logic        r_ov;
    t_out_item   r_out;

    logic          acc, acc_load, acc_read;
    logic [AW-1:0] cnt0;
    logic [AW-1:0] mask, half, bb, fi, fj;
    logic [LOGN-1:0] tw_t;
    logic [SW-1:0]   tw_sh;
    logic          issue;

    logic          we, re;
    logic [AW-1:0] waddr, raddr0, raddr1;
    logic [63:0]   wre, wim;
    logic [63:0]   rd0_re, rd0_im, rd1_re, rd1_im;
    logic signed [63:0] pr, pi;
    t_bf_ctl       bf_ctl;

    logic [63:0] fwd_v, rnd;
    logic [31:0] r32;
    logic        bwd_last;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign acc         = i_in_valid && o_in_ready;
    assign acc_load    = acc && (i_in_item.mode == MODE_FWD || i_in_item.mode == MODE_BWD);
    assign acc_read    = acc && (i_in_item.mode == MODE_READ);
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // a load after finished results, or of the other direction, starts over
    assign cnt0  = (r_ready || (r_dir != i_in_item.mode[0])) ? '0 : r_cnt;
    assign fwd_v = 64'($signed(i_in_item.sample_re[31:0])) << FRAC_BITS;

    // butterfly index -> addresses and twiddle index
    assign mask  = ~({AW{1'b1}} << r_stg);
    assign half  = AW'(1) << r_stg;
    assign bb    = {1'b0, r_b};
    assign fi    = bb + (bb & ~mask);
    assign fj    = fi + half;
    assign tw_sh = SW'(LOGN) - r_stg;
    assign tw_t  = LOGN'((bb & mask) << tw_sh);
    assign issue = (r_state == ST_FFT) && !r_s[1] && !r_idone && !(r_first && (|r_s));

    assign bf_ctl.lo_en  = r_s[1];
    assign bf_ctl.hi_en  = r_s[2];
    assign bf_ctl.cmb_en = r_s[3];

    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wre   = '0;
        wim   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_load) begin
                    we = 1'b1;
                    if (i_in_item.mode == MODE_FWD) begin
                        waddr = f_rev({1'b0, cnt0[LOGN-1:0]});
                        wre   = fwd_v;
                    end else begin
                        waddr = f_rev({cnt0[AW-2:0], 1'b1});
                        wre   = i_in_item.sample_re;
                        wim   = i_in_item.sample_im;
                    end
                end
            end
            ST_LOADB2: begin
                we    = 1'b1;
                waddr = r_b2addr;
                wre   = r_bre;
                wim   = r_bim;
            end
            ST_SWEEP: begin
                we    = 1'b1;
                waddr = r_dir ? f_rev({r_swp, 1'b0}) : f_rev({1'b1, r_swp});
            end
            ST_FFT: begin
                if (r_s[4]) begin
                    we    = 1'b1;
                    waddr = r_aj[4];
                    wre   = r_a2re - pr;
                    wim   = r_a2im - pi;
                end else if (r_s[5]) begin
                    we    = 1'b1;
                    waddr = r_ai[5];
                    wre   = r_a2re + pr;
                    wim   = r_a2im + pi;
                end
            end
            default: ;
        endcase
    end

    assign re     = issue || acc_read;
    assign raddr0 = issue ? fi :
                    (r_dir ? {1'b0, r_ridx[LOGN-1:0]} : {r_ridx[AW-2:0], 1'b1});
    assign raddr1 = fj;

    nft_ram #(.WIDTH(64), .DEPTH(FULL_LEN)) u_ram_re (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wre),
        .i_re     (re),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rd0_re),
        .o_rdata1 (rd1_re)
    );

    nft_ram #(.WIDTH(64), .DEPTH(FULL_LEN)) u_ram_im (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wim),
        .i_re     (re),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rd0_im),
        .o_rdata1 (rd1_im)
    );

    nft_bfly u_bfly (
        .i_clk (i_clk),
        .i_ctl (bf_ctl),
        .i_wr  (r_wr),
        .i_wi  (r_wi),
        .i_xr  (rd1_re),
        .i_xi  (rd1_im),
        .o_pr  (pr),
        .o_pi  (pi)
    );

    // backward rounding, half away from zero, kept to 32 bits
    assign rnd      = (r_mag + (64'd1 << (RB_SH - 1))) >> RB_SH;
    assign r32      = r_neg ? -rnd[31:0] : rnd[31:0];
    assign bwd_last = (r_ridx == AW'(HALF_LEN - 1));

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (acc_load && i_in_item.mode == MODE_BWD) begin
            r_b2addr <= f_rev(~{cnt0[AW-2:0], 1'b0});
            r_bre    <= i_in_item.sample_re;
            r_bim    <= -i_in_item.sample_im;
        end
        if (issue) begin
            r_wr <= COS_TAB[tw_t];
            r_wi <= r_dir ? SIN_TAB[tw_t] : -SIN_TAB[tw_t];
        end
        r_ai[1] <= fi;
        r_aj[1] <= fj;
        for (int k = 2; k <= 5; k++) begin
            r_ai[k] <= r_ai[k-1];
            r_aj[k] <= r_aj[k-1];
        end
        if (r_s[2]) begin
            r_a1re <= rd0_re;
            r_a1im <= rd0_im;
        end
        if (r_s[3]) begin
            r_a2re <= r_a1re;
            r_a2im <= r_a1im;
        end
        if (r_state == ST_RD1) begin
            r_neg <= rd0_re[63];
            r_mag <= rd0_re[63] ? -rd0_re : rd0_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dir   <= 1'b0;
            r_ready <= 1'b0;
            r_cnt   <= '0;
            r_ridx  <= '0;
            r_blast <= 1'b0;
            r_swp   <= '0;
            r_b     <= '0;
            r_stg   <= '0;
            r_first <= 1'b0;
            r_idone <= 1'b0;
            r_s     <= '0;
            r_ov    <= 1'b0;
            r_pend  <= '0;
            r_out   <= '0;
        end else begin
            r_s <= {r_s[4:1], issue};
            if (r_state == ST_RDOUT && (!r_ov || i_out_ready)) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (acc_load) begin
                        r_dir   <= i_in_item.mode[0];
                        r_ready <= 1'b0;
                        if (i_in_item.mode == MODE_FWD && cnt0 == AW'(HALF_LEN - 1)) begin
                            r_cnt   <= '0;
                            r_ridx  <= '0;
                            r_swp   <= '0;
                            r_state <= ST_SWEEP;
                        end else begin
                            r_cnt <= cnt0 + AW'(1);
                            if (r_ready) begin
                                r_ridx <= '0;
                            end
                            if (i_in_item.mode == MODE_BWD) begin
                                r_blast <= (cnt0 == AW'(HALF_LEN / 2 - 1));
                                r_state <= ST_LOADB2;
                            end
                        end
                    end else if (acc_read) begin
                        r_state <= ST_RD1;
                    end
                end
                ST_LOADB2: begin
                    if (r_blast) begin
                        r_cnt   <= '0;
                        r_ridx  <= '0;
                        r_swp   <= '0;
                        r_state <= ST_SWEEP;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_SWEEP: begin
                    r_swp <= r_swp + LOGN'(1);
                    if (&r_swp) begin
                        r_b     <= '0;
                        r_stg   <= '0;
                        r_first <= 1'b1;
                        r_idone <= 1'b0;
                        r_state <= ST_FFT;
                    end
                end
                ST_FFT: begin
                    if (issue) begin
                        r_b     <= r_b + LOGN'(1);
                        r_first <= &r_b;
                        if (&r_b) begin
                            if (r_stg == SW'(LOGN)) begin
                                r_idone <= 1'b1;
                            end else begin
                                r_stg <= r_stg + SW'(1);
                            end
                        end
                    end
                    if (r_idone && !(|r_s)) begin
                        r_ready <= 1'b1;
                        r_ridx  <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD1: begin
                    if (!r_ready) begin
                        r_pend  <= '0;
                        r_state <= ST_RDOUT;
                    end else if (!r_dir) begin
                        r_state <= ST_RDOUT;
                        if (r_ridx == AW'(HALF_LEN / 2)) begin
                            r_pend  <= '{out_re: '0, out_im: '0, data_ok: 1'b1,
                                         last_result: 1'b1};
                            r_ready <= 1'b0;
                            r_ridx  <= '0;
                        end else begin
                            r_pend <= '{out_re: rd0_re, out_im: rd0_im, data_ok: 1'b1,
                                        last_result: 1'b0};
                            r_ridx <= r_ridx + AW'(1);
                        end
                    end else begin
                        r_state <= ST_RD2;
                    end
                end
                ST_RD2: begin
                    r_pend <= '{out_re: 64'($signed(r32)), out_im: '0, data_ok: 1'b1,
                                last_result: bwd_last};
                    if (bwd_last) begin
                        r_ready <= 1'b0;
                        r_ridx  <= '0;
                    end else begin
                        r_ridx <= r_ridx + AW'(1);
                    end
                    r_state <= ST_RDOUT;
                end
                ST_RDOUT: begin
                    if (!r_ov || i_out_ready) begin
                        r_out   <= r_pend;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

### src/nft_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// Standalone; used for the real and imaginary work memories.
module nft_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

### src/nft_bfly.sv
// Butterfly product datapath: four twiddle products, each split in two halves.
// Depends on nft_pkg.
module nft_bfly import nft_pkg::*; (
    input  logic                   i_clk,
    input  t_bf_ctl                i_ctl,
    input  logic signed [TW_W-1:0] i_wr,
    input  logic signed [TW_W-1:0] i_wi,
    input  logic signed [63:0]     i_xr,
    input  logic signed [63:0]     i_xi,
    output logic signed [63:0]     o_pr,
    output logic signed [63:0]     o_pi
);

    localparam int PW = TW_W + 33;
    localparam int CW = PW + 32;

    logic signed [32:0]   op_r, op_i;
    logic signed [PW-1:0] m_a, m_b, m_c, m_d;
    logic signed [PW-1:0] r_lo_a, r_lo_b, r_lo_c, r_lo_d;
    logic signed [PW-1:0] r_hi_a, r_hi_b, r_hi_c, r_hi_d;

    // low half is unsigned, high half carries the sign
    assign op_r = i_ctl.lo_en ? $signed({1'b0, i_xr[31:0]}) : $signed({i_xr[63], i_xr[63:32]});
    assign op_i = i_ctl.lo_en ? $signed({1'b0, i_xi[31:0]}) : $signed({i_xi[63], i_xi[63:32]});

    assign m_a = i_wr * op_r;
    assign m_b = i_wi * op_i;
    assign m_c = i_wr * op_i;
    assign m_d = i_wi * op_r;

    function automatic logic [63:0] f_rnd(input logic signed [PW-1:0] hi,
                                          input logic signed [PW-1:0] lo);
        logic signed [CW-1:0] s;
        s = (CW'(hi) <<< 32) + CW'(lo) + (CW'(1) <<< (TWIDDLE_BITS - 1));
        return s[TWIDDLE_BITS+63:TWIDDLE_BITS];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctl.lo_en) begin
            r_lo_a <= m_a;
            r_lo_b <= m_b;
            r_lo_c <= m_c;
            r_lo_d <= m_d;
        end
        if (i_ctl.hi_en) begin
            r_hi_a <= m_a;
            r_hi_b <= m_b;
            r_hi_c <= m_c;
            r_hi_d <= m_d;
        end
        if (i_ctl.cmb_en) begin
            o_pr <= f_rnd(r_hi_a, r_lo_a) - f_rnd(r_hi_b, r_lo_b);
            o_pi <= f_rnd(r_hi_c, r_lo_c) + f_rnd(r_hi_d, r_lo_d);
        end
    end

endmodule
